/* hdl/cubic_bezier_eased_point_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the eased Bezier point block
// Clocked on clk, muted while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EASED_POINT_DEFINES_SVH
`define CUBIC_BEZIER_EASED_POINT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CBEP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CBEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cbep_pkg.sv */
// ----------------------------------------------------------------------------
// cbep_pkg
// Shared types and constants of the eased Bezier point block.
// ----------------------------------------------------------------------------
package cbep_pkg;

  // Q1.16 one
  localparam logic [16:0] Q16_ONE = 17'h10000;

  // Bisection limits
  localparam int unsigned MAX_STEPS     = 100;
  localparam int unsigned TOLERANCE_Q16 = 66;
  localparam int unsigned STEP_W        = $clog2(MAX_STEPS + 1);

  // Shared multiply-accumulate unit: signed a, unsigned b, signed accumulator
  localparam int unsigned MAC_A_W = 25;
  localparam int unsigned MAC_B_W = 19;
  localparam int unsigned PROD_W  = MAC_A_W + MAC_B_W + 1;
  localparam int unsigned ACC_W   = 47;

  typedef struct packed {
    logic        en;     // load the accumulator
    logic        accum;  // add the product instead of replacing
  } mac_ctl_t;

  typedef struct packed {
    logic [16:0]        ease_first_x;
    logic [16:0]        ease_first_y;
    logic [16:0]        ease_second_x;
    logic [16:0]        ease_second_y;
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] ctrl_a_x;
    logic signed [23:0] ctrl_a_y;
    logic signed [23:0] ctrl_b_x;
    logic signed [23:0] ctrl_b_y;
    logic signed [23:0] end_x;
    logic signed [23:0] end_y;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
  } out_word_t;

endpackage

/* hdl/cbep_mac.sv */
// ----------------------------------------------------------------------------
// cbep_mac
// Shared multiplier with a registered accumulator.
// ----------------------------------------------------------------------------
module cbep_mac (
  input  logic                                 clk,
  input  cbep_pkg::mac_ctl_t                   ctl,
  input  logic signed [cbep_pkg::MAC_A_W-1:0]  a,
  input  logic        [cbep_pkg::MAC_B_W-1:0]  b,
  output logic signed [cbep_pkg::ACC_W-1:0]    acc
);
  import cbep_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;

  always_comb begin
    prod = a * $signed({1'b0, b});
    if (ctl.accum) begin
      acc_nxt = acc_r + ACC_W'(prod);
    end else begin
      acc_nxt = ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

/* hdl/cubic_bezier_eased_point.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_eased_point
// Eases the configured animation fraction through a cubic timing curve by
// bisection, then returns the point on a cubic Bezier path at that speed.
// ----------------------------------------------------------------------------
//
//   channel  ports                          handshake
//   -------  -----------------------------  ------------------------------
//   input    start, busy, in_data           word taken when start & !busy
//   result   out_valid, out_data            one-cycle strobe, no backpressure
//   config   cfg_we, cfg_wdata              written whenever cfg_we is high
//
// busy stays high through every bisection step and then through the speed
// and path evaluation, which follows ST_MID when the search ends on a
// repeated midpoint. The search takes N steps, N <= MAX_STEPS, in practice
// at most 17 because it stops once its midpoint repeats; the next word can
// be taken in the strobe cycle of this one.
// Every product goes through the single shared multiplier, one per cycle.
// busy stays high from the accepting edge until the edge that raises
// out_valid; a new word may start in the strobe cycle.
// rst_n is synchronous and clears the sequencer, the strobe and the fraction.
// Nothing can stall the result side: each result shows for one cycle only.
//
module cubic_bezier_eased_point (
  input  logic                clk,
  input  logic                rst_n,
  // input words
  input  logic                start,
  output logic                busy,
  input  cbep_pkg::in_word_t  in_data,
  // configuration
  input  logic                cfg_we,
  input  logic [16:0]         cfg_wdata,
  // results
  output logic                out_valid,
  output cbep_pkg::out_word_t out_data
);
  import cbep_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MID   = 4'd1;   // pick the next midpoint
  localparam logic [3:0] ST_TT    = 4'd2;   // t*t
  localparam logic [3:0] ST_UU    = 4'd3;   // u*u
  localparam logic [3:0] ST_T3    = 4'd4;   // t2*t
  localparam logic [3:0] ST_B1    = 4'd5;   // u2*t
  localparam logic [3:0] ST_B2    = 4'd6;   // t2*u
  localparam logic [3:0] ST_U3    = 4'd7;   // u2*u
  localparam logic [3:0] ST_C1    = 4'd8;   // first weighted term
  localparam logic [3:0] ST_C2    = 4'd9;
  localparam logic [3:0] ST_C3    = 4'd10;
  localparam logic [3:0] ST_C4    = 4'd11;
  localparam logic [3:0] ST_EVAL  = 4'd12;  // finish a timing cubic
  localparam logic [3:0] ST_ROUND = 4'd13;  // round and clamp a path sum

  // What the timing cubic is being used for
  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_YEVAL  = 2'd1;
  localparam logic [1:0] PH_PATH   = 2'd2;

  // Control registers
  logic [3:0]        state_r,  state_nxt;
  logic [1:0]        phase_r,  phase_nxt;
  logic [STEP_W-1:0] step_r,   step_nxt;
  logic              coord_r,  coord_nxt;
  logic              valid_r,  valid_nxt;
  logic [16:0]       frac_r,   frac_nxt;

  // Payload registers
  in_word_t          word_r,   word_nxt;
  logic [16:0]       lo_r,     lo_nxt;
  logic [16:0]       hi_r,     hi_nxt;
  logic [16:0]       t_r,      t_nxt;
  logic [16:0]       u_r,      u_nxt;
  logic [16:0]       t2_r,     t2_nxt;
  logic [16:0]       u2_r,     u2_nxt;
  logic [16:0]       t3_r,     t3_nxt;
  logic [16:0]       u3_r,     u3_nxt;
  logic [18:0]       tb1_r,    tb1_nxt;  // 3*b1
  logic [18:0]       tb2_r,    tb2_nxt;  // 3*b2
  logic signed [23:0] px_r,    px_nxt;
  out_word_t         res_r,    res_nxt;

  // Shared unit
  mac_ctl_t                 mac_ctl;
  logic signed [MAC_A_W-1:0] mac_a;
  logic        [MAC_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   acc;

  // Datapath helpers
  logic [16:0]        acc_hi;
  logic [18:0]        acc_hi3;
  logic [17:0]        mid_sum;
  logic [16:0]        mid;
  logic [21:0]        est;
  logic [21:0]        tgt;
  logic [21:0]        gap;
  logic               est_lt;
  logic               in_tol;
  logic [16:0]        speed;
  logic signed [ACC_W-1:0] rsum;
  logic signed [30:0] rsh;
  logic signed [23:0] rsat;
  logic signed [23:0] pt0, pt1, pt2, pt3;
  logic [16:0]        ease1, ease2;

  cbep_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  always_comb begin
    // product of two Q16 terms, back to Q16
    acc_hi  = acc[32:16];
    acc_hi3 = {1'b0, acc_hi, 1'b0} + 19'(acc_hi);

    mid_sum = 18'(lo_r) + 18'(hi_r);
    mid     = mid_sum[17:1];

    // timing cubic and its distance from the target
    est    = 22'(acc[36:16]) + 22'(t3_r);
    tgt    = 22'(frac_r);
    est_lt = (est < tgt);
    gap    = est_lt ? (tgt - est) : (est - tgt);
    in_tol = (gap <= 22'(TOLERANCE_Q16));
    speed  = (est > 22'(Q16_ONE)) ? Q16_ONE : est[16:0];

    // round half up, then clamp to 24 bits
    rsum = acc + ACC_W'(32768);
    rsh  = rsum[46:16];
    if (rsh > 31'sd8388607) begin
      rsat = 24'sh7FFFFF;
    end else if (rsh < -31'sd8388608) begin
      rsat = 24'sh800000;
    end else begin
      rsat = rsh[23:0];
    end

    // operands of the current cubic
    pt0   = coord_r ? word_r.start_y  : word_r.start_x;
    pt1   = coord_r ? word_r.ctrl_a_y : word_r.ctrl_a_x;
    pt2   = coord_r ? word_r.ctrl_b_y : word_r.ctrl_b_x;
    pt3   = coord_r ? word_r.end_y    : word_r.end_x;
    ease1 = (phase_r == PH_SEARCH) ? word_r.ease_first_x  : word_r.ease_first_y;
    ease2 = (phase_r == PH_SEARCH) ? word_r.ease_second_x : word_r.ease_second_y;
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    coord_nxt = coord_r;
    valid_nxt = 1'b0;
    frac_nxt  = cfg_we ? cfg_wdata : frac_r;
    word_nxt  = word_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    t_nxt     = t_r;
    u_nxt     = u_r;
    t2_nxt    = t2_r;
    u2_nxt    = u2_r;
    t3_nxt    = t3_r;
    u3_nxt    = u3_r;
    tb1_nxt   = tb1_r;
    tb2_nxt   = tb2_r;
    px_nxt    = px_r;
    res_nxt   = res_r;
    mac_ctl   = '0;
    mac_a     = '0;
    mac_b     = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          word_nxt  = in_data;
          lo_nxt    = '0;
          hi_nxt    = Q16_ONE;
          step_nxt  = '0;
          coord_nxt = 1'b0;
          phase_nxt = PH_SEARCH;
          state_nxt = ST_MID;
        end
      end
      ST_MID: begin
        // a repeated midpoint gives the same verdict forever: stop there
        if ((step_r != '0) && (mid == t_r)) begin
          phase_nxt = PH_YEVAL;
          state_nxt = ST_C1;
        end else begin
          t_nxt     = mid;
          state_nxt = ST_TT;
        end
      end
      ST_TT: begin
        mac_ctl.en = 1'b1;
        mac_a      = MAC_A_W'(t_r);
        mac_b      = MAC_B_W'(t_r);
        u_nxt      = Q16_ONE - t_r;
        state_nxt  = ST_UU;
      end
      ST_UU: begin
        t2_nxt     = acc_hi;
        mac_ctl.en = 1'b1;
        mac_a      = MAC_A_W'(u_r);
        mac_b      = MAC_B_W'(u_r);
        state_nxt  = ST_T3;
      end
      ST_T3: begin
        u2_nxt     = acc_hi;
        mac_ctl.en = 1'b1;
        mac_a      = MAC_A_W'(t2_r);
        mac_b      = MAC_B_W'(t_r);
        state_nxt  = ST_B1;
      end
      ST_B1: begin
        t3_nxt     = acc_hi;
        mac_ctl.en = 1'b1;
        mac_a      = MAC_A_W'(u2_r);
        mac_b      = MAC_B_W'(t_r);
        state_nxt  = ST_B2;
      end
      ST_B2: begin
        tb1_nxt    = acc_hi3;
        mac_ctl.en = 1'b1;
        mac_a      = MAC_A_W'(t2_r);
        mac_b      = MAC_B_W'(u_r);
        state_nxt  = ST_U3;
      end
      ST_U3: begin
        tb2_nxt    = acc_hi3;
        mac_ctl.en = 1'b1;
        mac_a      = MAC_A_W'(u2_r);
        mac_b      = MAC_B_W'(u_r);
        state_nxt  = ST_C1;
      end
      ST_C1: begin
        // accumulator holds u3 only on the first pass after the basis
        if (!coord_r) begin
          u3_nxt = acc_hi;
        end
        mac_ctl.en = 1'b1;
        mac_a      = (phase_r == PH_PATH) ? MAC_A_W'(pt1) : MAC_A_W'(ease1);
        mac_b      = tb1_r;
        state_nxt  = ST_C2;
      end
      ST_C2: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_a         = (phase_r == PH_PATH) ? MAC_A_W'(pt2) : MAC_A_W'(ease2);
        mac_b         = tb2_r;
        state_nxt     = (phase_r == PH_PATH) ? ST_C3 : ST_EVAL;
      end
      ST_C3: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_a         = MAC_A_W'(pt3);
        mac_b         = MAC_B_W'(t3_r);
        state_nxt     = ST_C4;
      end
      ST_C4: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mac_a         = MAC_A_W'(pt0);
        mac_b         = MAC_B_W'(u3_r);
        state_nxt     = ST_ROUND;
      end
      ST_EVAL: begin
        if (phase_r == PH_SEARCH) begin
          if (in_tol) begin
            phase_nxt = PH_YEVAL;
            state_nxt = ST_C1;
          end else begin
            if (est_lt) begin
              lo_nxt = t_r;
            end else begin
              hi_nxt = t_r;
            end
            if (step_r == STEP_W'(MAX_STEPS - 1)) begin
              phase_nxt = PH_YEVAL;
              state_nxt = ST_C1;
            end else begin
              step_nxt  = step_r + 1'b1;
              state_nxt = ST_MID;
            end
          end
        end else begin
          // speed found: rebuild the basis at it for the path
          t_nxt     = speed;
          phase_nxt = PH_PATH;
          state_nxt = ST_TT;
        end
      end
      ST_ROUND: begin
        if (!coord_r) begin
          px_nxt    = rsat;
          coord_nxt = 1'b1;
          state_nxt = ST_C1;
        end else begin
          res_nxt.point_x = px_r;
          res_nxt.point_y = rsat;
          valid_nxt       = 1'b1;
          coord_nxt       = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_SEARCH;
      step_r  <= '0;
      coord_r <= 1'b0;
      valid_r <= 1'b0;
      frac_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      coord_r <= coord_nxt;
      valid_r <= valid_nxt;
      frac_r  <= frac_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    t_r    <= t_nxt;
    u_r    <= u_nxt;
    t2_r   <= t2_nxt;
    u2_r   <= u2_nxt;
    t3_r   <= t3_nxt;
    u3_r   <= u3_nxt;
    tb1_r  <= tb1_nxt;
    tb2_r  <= tb2_nxt;
    px_r   <= px_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;
  assign out_data  = res_r;

endmodule

/* hdl/cbep_checker.sv */
// ----------------------------------------------------------------------------
// cbep_checker
// Port-level timing checks of the eased Bezier point block.
// ----------------------------------------------------------------------------
`include "cubic_bezier_eased_point_defines.svh"

module cbep_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // an accepted word starts work at once
  `CBEP_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
  // each word yields one strobe, never two in a row
  `CBEP_ASSERT_NEXT(a_strobe_pulse, out_valid, !out_valid, "result strobe held past one cycle")
  // a result always ends a busy stretch
  `CBEP_ASSERT_SAME(a_strobe_after, out_valid, $past(busy) && !busy, "strobe without prior work")
  // work never ends without a result
  `CBEP_ASSERT_SAME(a_done_strobe, $fell(busy) && $past(rst_n), out_valid, "busy dropped, no result")

endmodule

bind cubic_bezier_eased_point cbep_checker u_cbep_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for cubic_bezier_eased_point
// Drives easing curves and Bezier paths into the block under a range of
// animation fractions. Each result word is checked against a fixed answer
// or a predicted path point, computed here by the same integer bisection.
// ----------------------------------------------------------------------------
module tb;

  import cbep_pkg::*;

  // Bisection limits of the easing search
  localparam int STEP_LIMIT = 100;
  localparam int TOL        = 66;

  // Handy field values for the stimulus table
  localparam int E1   = 65536;     // 1.0 in Q1.16
  localparam int EMAX = 131071;    // largest 17-bit value
  localparam int PMAX = 8388607;   // largest signed 24-bit value
  localparam int PMIN = -8388608;  // smallest signed 24-bit value

  // Number of random words per fraction setting, and number of settings
  localparam int PHASE_WORDS = 212;
  localparam int PHASES      = 8;

  // Budget the slowest legal word plus the longest sender gap over every word,
  // and then several times over.
  localparam int unsigned WATCHDOG_CYCLES = 8_000_000;
  localparam int          TAIL_CYCLES     = 250;
  localparam int          MAX_PRINTS      = 200;

  typedef struct packed {
    longint t3;
    longint u3;
    longint b1;
    longint b2;
  } bern_w_t;

  // One line of the directed table: fraction, word, and optional fixed answer
  typedef struct packed {
    logic [16:0] frac;
    in_word_t    word;
    logic        typed;
    out_word_t   want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_data;
  logic      cfg_we;
  logic [16:0] cfg_wdata;
  logic      out_valid;
  out_word_t out_data;

  // Fixed answer travelling with the word on the bus (directed rows only)
  logic      typed_on;
  out_word_t typed_word;

  out_word_t   point_q[$];    // predicted path points, oldest first
  logic [16:0] frac_shadow;   // fraction as the block holds it
  logic [16:0] frac_now;      // fraction last written by the sender
  int unsigned cyc;
  int          err_cnt;
  dir_row_t    dir_tab[$];

  cubic_bezier_eased_point i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Bernstein weights at parameter t (Q1.16), each product floored to Q16
  function automatic bern_w_t bern_weights(input longint t);
    longint  u;
    longint  t2;
    longint  u2;
    bern_w_t w;
    u    = 65536 - t;
    t2   = (t * t) >> 16;
    u2   = (u * u) >> 16;
    w.t3 = (t2 * t) >> 16;
    w.u3 = (u2 * u) >> 16;
    w.b1 = (u2 * t) >> 16;
    w.b2 = (t2 * u) >> 16;
    return w;
  endfunction

  // Timing cubic with end points (0,0) and (1,1)
  function automatic longint timing_curve(input longint p1, input longint p2,
                                          input longint t);
    bern_w_t w;
    w = bern_weights(t);
    return ((3 * p1 * w.b1 + 3 * p2 * w.b2) >> 16) + w.t3;
  endfunction

  // One axis of the path: weighted sum, round half up, saturate to 24 bits
  function automatic logic signed [23:0] path_axis(input bern_w_t w,
                                                   input logic signed [23:0] p0,
                                                   input logic signed [23:0] p1,
                                                   input logic signed [23:0] p2,
                                                   input logic signed [23:0] p3);
    longint s;
    longint v;
    s = longint'(p0) * w.u3 + longint'(p1) * (3 * w.b1)
      + longint'(p2) * (3 * w.b2) + longint'(p3) * w.t3;
    v = (s + 32768) >>> 16;
    if (v > PMAX) v = PMAX;
    if (v < PMIN) v = PMIN;
    return v[23:0];
  endfunction

  // Bisect the x cubic toward the fraction, then evaluate speed and path
  function automatic out_word_t eased_point(input in_word_t w, input logic [16:0] frac);
    longint    lo;
    longint    hi;
    longint    mid;
    longint    est;
    longint    diff;
    longint    spd;
    longint    target;
    logic      hit;
    int        k;
    bern_w_t   bw;
    out_word_t r;
    target = longint'(frac);
    lo     = 0;
    hi     = 65536;
    mid    = 0;
    hit    = 1'b0;
    for (k = 0; k < STEP_LIMIT && !hit; k++) begin
      mid  = (lo + hi) >> 1;
      est  = timing_curve(w.ease_first_x, w.ease_second_x, mid);
      diff = est - target;
      if (diff < 0) diff = -diff;
      if (diff <= TOL) begin
        hit = 1'b1;
      end else if (est < target) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    // Clamp the speed to one; it cannot go negative
    spd = timing_curve(w.ease_first_y, w.ease_second_y, mid);
    if (spd > 65536) spd = 65536;
    bw = bern_weights(spd);
    r.point_x = path_axis(bw, w.start_x, w.ctrl_a_x, w.ctrl_b_x, w.end_x);
    r.point_y = path_axis(bw, w.start_y, w.ctrl_a_y, w.ctrl_b_y, w.end_y);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc, what, got, want);
  endtask

  // Sample on the rising edge: shadow the fraction, record accepted words,
  // and compare each strobed result with the oldest prediction.
  always @(posedge clk) begin
    out_word_t exp_w;
    cyc <= cyc + 1;
    if (cyc == WATCHDOG_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cyc, point_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n) begin
      if (cfg_we)
        frac_shadow = cfg_wdata;
      if (start && !busy)
        point_q = {point_q, (typed_on ? typed_word : eased_point(in_data, frac_shadow))};
      if (out_valid) begin
        if (point_q.size() == 0) begin
          report_mismatch("unexpected word, point_x", int'(out_data.point_x), 0);
        end else begin
          exp_w = point_q.pop_front();
          if (out_data.point_x !== exp_w.point_x)
            report_mismatch("point_x", int'(out_data.point_x), int'(exp_w.point_x));
          if (out_data.point_y !== exp_w.point_y)
            report_mismatch("point_y", int'(out_data.point_y), int'(exp_w.point_y));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Append one directed row; a set typed flag fixes the answer in the table
  task automatic add_row(input int frac, input int ex1, input int ey1,
                         input int ex2, input int ey2,
                         input int sx, input int sy, input int ax, input int ay,
                         input int bx, input int by, input int nx, input int ny,
                         input bit typed, input int px, input int py);
    dir_row_t r;
    r.frac               = frac[16:0];
    r.word.ease_first_x  = ex1[16:0];
    r.word.ease_first_y  = ey1[16:0];
    r.word.ease_second_x = ex2[16:0];
    r.word.ease_second_y = ey2[16:0];
    r.word.start_x       = sx[23:0];
    r.word.start_y       = sy[23:0];
    r.word.ctrl_a_x      = ax[23:0];
    r.word.ctrl_a_y      = ay[23:0];
    r.word.ctrl_b_x      = bx[23:0];
    r.word.ctrl_b_y      = by[23:0];
    r.word.end_x         = nx[23:0];
    r.word.end_y         = ny[23:0];
    r.typed              = typed;
    r.want.point_x       = px[23:0];
    r.want.point_y       = py[23:0];
    dir_tab = {dir_tab, r};
  endtask

  // Easing control value: mostly within [0,1], sometimes above one or extreme
  function automatic logic [16:0] rand_ease();
    case ($urandom_range(9))
      0:       return 17'd0;
      1:       return 17'(E1);
      2:       return 17'($urandom_range(EMAX));
      3:       return 17'(EMAX);
      default: return 17'($urandom_range(E1));
    endcase
  endfunction

  // Path coordinate: full range, extremes, or near the origin
  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(9))
      0:       return 24'(PMIN);
      1:       return 24'(PMAX);
      2:       return 24'($urandom_range(4095)) - 24'sd2048;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.ease_first_x  = rand_ease();
    w.ease_first_y  = rand_ease();
    w.ease_second_x = rand_ease();
    w.ease_second_y = rand_ease();
    w.start_x       = rand_coord();
    w.start_y       = rand_coord();
    w.ctrl_a_x      = rand_coord();
    w.ctrl_a_y      = rand_coord();
    w.ctrl_b_x      = rand_coord();
    w.ctrl_b_y      = rand_coord();
    w.end_x         = rand_coord();
    w.end_y         = rand_coord();
    return w;
  endfunction

  // Sender gap before the next word: short ones hit the accept edge, long
  // ones land anywhere inside the block's bisection and path evaluation.
  function automatic int pick_gap(input bit idle_on);
    if (!idle_on || $urandom_range(99) >= 28) return 0;
    if ($urandom_range(1) == 1) return $urandom_range(1, 3);
    return $urandom_range(4, 250);
  endfunction

  // Present one word from a falling edge and hold it until taken; leave
  // start high so a back-to-back word needs no toggle.
  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want,
                           input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data    = w;
    typed_on   = typed;
    typed_word = want;
    start      = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start and hold off until every predicted word has come back
  task automatic wait_drained();
    start = 1'b0;
    while (point_q.size() != 0) @(negedge clk);
  endtask

  // Write the fraction only with the block idle
  task automatic set_fraction(input logic [16:0] v);
    wait_drained();
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    frac_now  = v;
  endtask

  initial begin
    in_word_t    w;
    out_word_t   no_want;
    logic [16:0] f;
    bit          idle_on;
    int          i;
    int          ph;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    typed_on    = 1'b0;
    typed_word  = '0;
    no_want     = '0;
    frac_shadow = '0;
    frac_now    = '0;
    cyc         = 0;
    err_cnt     = 0;

    // Directed table. Columns: fraction, ease x1 y1 x2 y2, start, ctrl_a,
    // ctrl_b, end, fixed-answer flag, answer x y.
    // First row runs on the reset fraction of zero: steep x ease stops the
    // search at a tiny parameter, flat y ease gives zero speed, so the
    // answer is the start point.
    add_row(0, E1, 0, E1, 0, 123456, -654321, PMAX, PMIN, PMIN, PMAX, 777, -777,
            1, 123456, -654321);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, EMAX, EMAX, EMAX, EMAX, PMAX, PMIN, PMIN, PMAX, PMAX, PMIN, PMIN, PMAX,
            0, 0, 0);
    // Half fraction meets the symmetric x ease on the first step; huge y ease
    // saturates the speed to one, so the answer is the end point.
    add_row(32768, 32768, EMAX, 32768, EMAX, 5, 6, 7, 8, 9, 10, PMIN, PMAX,
            1, PMIN, PMAX);
    add_row(32768, 32768, 0, 32768, 0, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN,
            0, 0, 0);
    add_row(32768, 16384, 50000, 49152, 15000, -256, 256, 1000, -1000, 4096, 8192,
            -51200, 25600, 0, 0, 0);
    add_row(E1, 0, E1, 0, E1, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX,
            0, 0, 0);
    add_row(E1, E1, 0, E1, E1, PMIN, PMAX, PMAX, PMIN, PMIN, PMAX, PMAX, PMIN,
            0, 0, 0);
    // Fraction above one: the search stops on a repeated midpoint, short of the step limit
    add_row(EMAX, EMAX, EMAX, 0, EMAX, -1, 1, -2, 2, -3, 3, -4, 4, 0, 0, 0);
    add_row(EMAX, 0, 0, 0, 0, PMIN, PMIN, PMAX, PMAX, PMIN, PMIN, PMAX, PMAX,
            0, 0, 0);
    add_row(1, 1, 1, 1, 1, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 0, 0, 0);
    // Fractions right at and just past the tolerance
    add_row(TOL, 0, E1, 0, 0, 100, 200, 300, 400, 500, 600, 700, 800, 0, 0, 0);
    add_row(TOL + 1, 0, E1, 0, 0, 100, 200, 300, 400, 500, 600, 700, 800, 0, 0, 0);
    add_row(0, 1, 0, EMAX, 0, 0, PMAX, 0, PMIN, 0, PMAX, 0, PMIN, 0, 0, 0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the table; rewrite the fraction only where a row changes it
    foreach (dir_tab[n]) begin
      if (dir_tab[n].frac != frac_now)
        set_fraction(dir_tab[n].frac);
      send_word(dir_tab[n].word, dir_tab[n].typed, dir_tab[n].want, pick_gap(1'b1));
    end

    // Random words over several fractions, extremes first
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       f = 17'(E1);
        1:       f = 17'd0;
        2:       f = 17'(EMAX);
        3:       f = 17'd1;
        4:       f = 17'($urandom_range(E1));
        5:       f = 17'($urandom_range(EMAX));
        6:       f = 17'($urandom_range(60000, E1));
        default: f = 17'($urandom_range(8000));
      endcase
      set_fraction(f);
      // keep one setting free of any sender idling
      idle_on = (ph != 3);
      for (i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(199) == 0)
          wait_drained();
        w = rand_word();
        send_word(w, 1'b0, no_want, pick_gap(idle_on));
      end
    end

    // Drain, then give any stray strobe a chance to show
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/cbep_pkg.sv
hdl/cbep_mac.sv
hdl/cubic_bezier_eased_point.sv
hdl/cbep_checker.sv
dv/tb.sv
